[hw/rtl/midrange_pic_instruction_execute_unit_assert.svh]
// Assertion macros shared by the execute unit RTL.
// Each macro checks a property on the rising edge of clk, held off while rst is high.
`ifndef MIDRANGE_PIC_INSTRUCTION_EXECUTE_UNIT_ASSERT_SVH
`define MIDRANGE_PIC_INSTRUCTION_EXECUTE_UNIT_ASSERT_SVH

// Immediate implication: the consequent must hold in the same cycle.
`define MPIE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: the consequent must hold in the next cycle.
`define MPIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mpie_pkg.sv]
// ----------------------------------------------------------------------------
// mpie_pkg
// Types, opcodes and constants of the mid-range instruction execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mpie_pkg;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int PC_WIDTH_DEF    = 13;
  localparam int PC_MAX_W        = 13;

  // Flag bit positions
  localparam int FL_C  = 0;
  localparam int FL_DC = 1;
  localparam int FL_Z  = 2;
  localparam int FL_PD = 3;
  localparam int FL_TO = 4;

  localparam logic [4:0] FLAGS_RESET = 5'b11000;

  // Instruction classes, bits 13:12
  localparam logic [1:0] CLS_BYTE = 2'd0;
  localparam logic [1:0] CLS_BIT  = 2'd1;
  localparam logic [1:0] CLS_JUMP = 2'd2;
  localparam logic [1:0] CLS_LIT  = 2'd3;

  // Miscellaneous codes, bits 6:0 with bits 13:7 clear
  localparam logic [6:0] MISC_RETURN = 7'h08;
  localparam logic [6:0] MISC_RETFIE = 7'h09;
  localparam logic [6:0] MISC_OPTION = 7'h62;
  localparam logic [6:0] MISC_SLEEP  = 7'h63;
  localparam logic [6:0] MISC_CLRWDT = 7'h64;

  // Byte-oriented opcodes, bits 11:8
  localparam logic [3:0] OP_MOVWF  = 4'h0;
  localparam logic [3:0] OP_CLR    = 4'h1;
  localparam logic [3:0] OP_SUBWF  = 4'h2;
  localparam logic [3:0] OP_DECF   = 4'h3;
  localparam logic [3:0] OP_IORWF  = 4'h4;
  localparam logic [3:0] OP_ANDWF  = 4'h5;
  localparam logic [3:0] OP_XORWF  = 4'h6;
  localparam logic [3:0] OP_ADDWF  = 4'h7;
  localparam logic [3:0] OP_MOVF   = 4'h8;
  localparam logic [3:0] OP_COMF   = 4'h9;
  localparam logic [3:0] OP_INCF   = 4'hA;
  localparam logic [3:0] OP_DECFSZ = 4'hB;
  localparam logic [3:0] OP_RRF    = 4'hC;
  localparam logic [3:0] OP_RLF    = 4'hD;
  localparam logic [3:0] OP_SWAPF  = 4'hE;
  localparam logic [3:0] OP_INCFSZ = 4'hF;

  // Bit-oriented opcodes, bits 11:10
  localparam logic [1:0] BOP_BCF   = 2'd0;
  localparam logic [1:0] BOP_BSF   = 2'd1;
  localparam logic [1:0] BOP_BTFSC = 2'd2;
  localparam logic [1:0] BOP_BTFSS = 2'd3;

  // Literal opcodes, bits 11:8
  localparam logic [3:0] LOP_MOVLW0 = 4'h0;
  localparam logic [3:0] LOP_MOVLW1 = 4'h1;
  localparam logic [3:0] LOP_MOVLW2 = 4'h2;
  localparam logic [3:0] LOP_MOVLW3 = 4'h3;
  localparam logic [3:0] LOP_RETLW0 = 4'h4;
  localparam logic [3:0] LOP_RETLW1 = 4'h5;
  localparam logic [3:0] LOP_RETLW2 = 4'h6;
  localparam logic [3:0] LOP_RETLW3 = 4'h7;
  localparam logic [3:0] LOP_IORLW  = 4'h8;
  localparam logic [3:0] LOP_ANDLW  = 4'h9;
  localparam logic [3:0] LOP_XORLW  = 4'hA;
  localparam logic [3:0] LOP_UNUSED = 4'hB;
  localparam logic [3:0] LOP_SUBLW0 = 4'hC;
  localparam logic [3:0] LOP_SUBLW1 = 4'hD;
  localparam logic [3:0] LOP_ADDLW0 = 4'hE;
  localparam logic [3:0] LOP_ADDLW1 = 4'hF;

  typedef struct packed {
    logic                file_write;
    logic [7:0]          write_data;
    logic [7:0]          w_value;
    logic [4:0]          flags;
    logic [PC_MAX_W-1:0] next_pc;
    logic                sleep_request;
    logic                option_write;
    logic                irq_return;
  } exec_res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/mpie_stack.sv]
// ----------------------------------------------------------------------------
// mpie_stack
// Circular return stack with wrap-around pointer; overflow overwrites oldest.
// ----------------------------------------------------------------------------
`default_nettype none

module mpie_stack #(
  parameter int STACK_DEPTH = mpie_pkg::STACK_DEPTH_DEF,
  parameter int PC_WIDTH    = mpie_pkg::PC_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mpie_pkg::stack_ctrl_t ctrl,
  input  wire logic [PC_WIDTH-1:0]  push_addr,
  output logic      [PC_WIDTH-1:0]  pop_addr
);
  import mpie_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

  logic [PC_WIDTH-1:0] entry [STACK_DEPTH];
  logic [SP_W-1:0]     sp;
  logic [SP_W-1:0]     sp_inc;
  logic [SP_W-1:0]     sp_dec;

  assign sp_inc   = (sp == SP_LAST) ? '0 : sp + 1'b1;
  assign sp_dec   = (sp == '0) ? SP_LAST : sp - 1'b1;
  assign pop_addr = entry[sp_dec];

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctrl.push) begin
      sp <= sp_inc;
    end else if (ctrl.pop) begin
      sp <= sp_dec;
    end
  end

  // Entries carry no reset: a return from an unwritten slot is undefined
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry[sp] <= push_addr;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mpie_exec.sv]
// ----------------------------------------------------------------------------
// mpie_exec
// Decode and single-pass execute of one 14-bit instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module mpie_exec #(
  parameter int PC_WIDTH = mpie_pkg::PC_WIDTH_DEF
) (
  input  wire logic [13:0]          instr,
  input  wire logic [7:0]           fv,
  input  wire logic [1:0]           page,
  input  wire logic [7:0]           w_cur,
  input  wire logic [4:0]           flags_cur,
  input  wire logic [PC_WIDTH-1:0]  pc_cur,
  input  wire logic [PC_WIDTH-1:0]  pop_addr,
  output mpie_pkg::exec_res_t       res,
  output mpie_pkg::stack_ctrl_t     sctl,
  output logic      [PC_WIDTH-1:0]  ret_addr
);
  import mpie_pkg::*;

  logic [3:0]          op;
  logic                d;
  logic [7:0]          k;
  logic [7:0]          bmask;
  logic [7:0]          alu_a;
  logic [8:0]          sum;
  logic [4:0]          sum_lo;
  logic [8:0]          diff;
  logic [7:0]          fv_dec;
  logic [7:0]          fv_inc;
  logic [PC_WIDTH-1:0] pc1;
  logic [PC_WIDTH-1:0] pc2;
  logic [PC_WIDTH-1:0] tgt;
  logic [PC_WIDTH-1:0] npc;
  logic [7:0]          r;
  logic                dest;
  logic                skip;
  logic [7:0]          w;
  logic [4:0]          fl;
  logic                fw;
  logic [7:0]          wd;

  assign op     = instr[11:8];
  assign d      = instr[7];
  assign k      = instr[7:0];
  assign bmask  = 8'(1) << instr[9:7];
  assign alu_a  = (instr[13:12] == CLS_LIT) ? k : fv;
  assign sum    = {1'b0, alu_a} + {1'b0, w_cur};
  assign sum_lo = {1'b0, alu_a[3:0]} + {1'b0, w_cur[3:0]};
  assign diff   = {1'b0, alu_a} - {1'b0, w_cur};
  assign fv_dec = fv - 8'd1;
  assign fv_inc = fv + 8'd1;
  assign pc1    = pc_cur + 1'b1;
  assign pc2    = pc1 + 1'b1;
  assign tgt    = PC_WIDTH'({page, instr[10:0]});
  assign ret_addr = pc1;

  always_comb begin
    w         = w_cur;
    fl        = flags_cur;
    fw        = 1'b0;
    wd        = 8'd0;
    r         = 8'd0;
    dest      = 1'b0;
    skip      = 1'b0;
    npc       = pc1;
    sctl      = '0;
    res       = '0;
    unique case (instr[13:12])
      CLS_BYTE: begin
        if (instr[13:7] == 7'd0) begin
          unique case (instr[6:0])
            MISC_RETURN: begin
              sctl.pop = 1'b1;
              npc      = pop_addr;
            end
            MISC_RETFIE: begin
              sctl.pop       = 1'b1;
              npc            = pop_addr;
              res.irq_return = 1'b1;
            end
            MISC_OPTION: res.option_write = 1'b1;
            MISC_SLEEP: begin
              fl[FL_PD]         = 1'b0;
              fl[FL_TO]         = 1'b1;
              res.sleep_request = 1'b1;
            end
            MISC_CLRWDT: begin
              fl[FL_PD] = 1'b1;
              fl[FL_TO] = 1'b1;
            end
            default: ;
          endcase
        end else begin
          dest = 1'b1;
          unique case (op)
            OP_MOVWF: begin
              fw   = 1'b1;
              wd   = w_cur;
              dest = 1'b0;
            end
            OP_CLR: begin
              fl[FL_Z] = 1'b1;
              dest     = 1'b0;
              if (d) begin
                fw = 1'b1;
              end else begin
                w = 8'd0;
              end
            end
            OP_SUBWF: begin
              r         = diff[7:0];
              fl[FL_Z]  = (r == 8'd0);
              fl[FL_C]  = !diff[8];
              fl[FL_DC] = (fv[3:0] >= w_cur[3:0]);
            end
            OP_DECF: begin
              r        = fv_dec;
              fl[FL_Z] = (r == 8'd0);
            end
            OP_IORWF: begin
              r        = fv | w_cur;
              fl[FL_Z] = (r == 8'd0);
            end
            OP_ANDWF: begin
              r        = fv & w_cur;
              fl[FL_Z] = (r == 8'd0);
            end
            OP_XORWF: begin
              r        = fv ^ w_cur;
              fl[FL_Z] = (r == 8'd0);
            end
            OP_ADDWF: begin
              r         = sum[7:0];
              fl[FL_Z]  = (r == 8'd0);
              fl[FL_C]  = sum[8];
              fl[FL_DC] = sum_lo[4];
            end
            OP_MOVF: begin
              r        = fv;
              fl[FL_Z] = (r == 8'd0);
            end
            OP_COMF: begin
              r        = ~fv;
              fl[FL_Z] = (r == 8'd0);
            end
            OP_INCF: begin
              r        = fv_inc;
              fl[FL_Z] = (r == 8'd0);
            end
            OP_DECFSZ: begin
              r    = fv_dec;
              skip = (r == 8'd0);
            end
            OP_RRF: begin
              r        = {flags_cur[FL_C], fv[7:1]};
              fl[FL_C] = fv[0];
            end
            OP_RLF: begin
              r        = {fv[6:0], flags_cur[FL_C]};
              fl[FL_C] = fv[7];
            end
            OP_SWAPF: r = {fv[3:0], fv[7:4]};
            OP_INCFSZ: begin
              r    = fv_inc;
              skip = (r == 8'd0);
            end
          endcase
          if (dest) begin
            if (d) begin
              fw = 1'b1;
              wd = r;
            end else begin
              w = r;
            end
          end
        end
      end
      CLS_BIT: begin
        unique case (instr[11:10])
          BOP_BCF: begin
            fw = 1'b1;
            wd = fv & ~bmask;
          end
          BOP_BSF: begin
            fw = 1'b1;
            wd = fv | bmask;
          end
          BOP_BTFSC: skip = ((fv & bmask) == 8'd0);
          BOP_BTFSS: skip = ((fv & bmask) != 8'd0);
        endcase
      end
      CLS_JUMP: begin
        // bit 11 clear is CALL: save the return address
        sctl.push = !instr[11];
        npc       = tgt;
      end
      CLS_LIT: begin
        unique case (op)
          LOP_MOVLW0, LOP_MOVLW1, LOP_MOVLW2, LOP_MOVLW3: w = k;
          LOP_RETLW0, LOP_RETLW1, LOP_RETLW2, LOP_RETLW3: begin
            w        = k;
            sctl.pop = 1'b1;
            npc      = pop_addr;
          end
          LOP_IORLW: begin
            w        = w_cur | k;
            fl[FL_Z] = (w == 8'd0);
          end
          LOP_ANDLW: begin
            w        = w_cur & k;
            fl[FL_Z] = (w == 8'd0);
          end
          LOP_XORLW: begin
            w        = w_cur ^ k;
            fl[FL_Z] = (w == 8'd0);
          end
          LOP_UNUSED: ;
          LOP_SUBLW0, LOP_SUBLW1: begin
            w         = diff[7:0];
            fl[FL_Z]  = (w == 8'd0);
            fl[FL_C]  = !diff[8];
            fl[FL_DC] = (k[3:0] >= w_cur[3:0]);
          end
          LOP_ADDLW0, LOP_ADDLW1: begin
            w         = sum[7:0];
            fl[FL_Z]  = (w == 8'd0);
            fl[FL_C]  = sum[8];
            fl[FL_DC] = sum_lo[4];
          end
        endcase
      end
    endcase
    if (skip) begin
      npc = pc2;
    end
    res.file_write = fw;
    res.write_data = wd;
    res.w_value    = w;
    res.flags      = fl;
    res.next_pc    = PC_MAX_W'(npc);
  end

endmodule

`default_nettype wire

[hw/rtl/midrange_pic_instruction_execute_unit.sv]
// Execute stage of a 14-bit mid-range microcontroller core. Each transfer on the input channel
// carries one instruction word, the file register byte it addresses and the PCLATH page bits;
// one result transfer follows with the write-back, W, flags, next PC and strobes. An item
// is held in the input register, is executed there against W, the flags, the PC and the
// return stack in a single combinational pass, and lands in the result register when it
// retires. A new instruction is taken every cycle while the result side keeps up. A stall
// on the result side holds the result register and then the input register.
`default_nettype none

module midrange_pic_instruction_execute_unit #(
  parameter int STACK_DEPTH = mpie_pkg::STACK_DEPTH_DEF,
  parameter int PC_WIDTH    = mpie_pkg::PC_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [13:0] instr_word,
  input  wire logic [7:0]  file_value,
  input  wire logic [1:0]  page_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             file_write,
  output logic [6:0]       file_addr,
  output logic [7:0]       write_data,
  output logic [7:0]       w_value,
  output logic [4:0]       flags,
  output logic [12:0]      next_pc,
  output logic             sleep_request,
  output logic             option_write,
  output logic             irq_return
);
  import mpie_pkg::*;
  `include "midrange_pic_instruction_execute_unit_assert.svh"

  logic                hold_valid;
  logic [13:0]         hold_instr;
  logic [7:0]          hold_file;
  logic [1:0]          hold_page;
  logic                advance;
  logic                accept;

  logic [7:0]          work_reg;
  logic [4:0]          status_flags;
  logic [PC_WIDTH-1:0] prog_counter;

  exec_res_t           res;
  stack_ctrl_t         sctl;
  stack_ctrl_t         sctl_gated;
  logic [PC_WIDTH-1:0] ret_addr;
  logic [PC_WIDTH-1:0] pop_addr;

  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign sctl_gated.push = sctl.push && advance;
  assign sctl_gated.pop  = sctl.pop && advance;

  mpie_exec #(
    .PC_WIDTH(PC_WIDTH)
  ) u_exec (
    .instr    (hold_instr),
    .fv       (hold_file),
    .page     (hold_page),
    .w_cur    (work_reg),
    .flags_cur(status_flags),
    .pc_cur   (prog_counter),
    .pop_addr (pop_addr),
    .res      (res),
    .sctl     (sctl),
    .ret_addr (ret_addr)
  );

  mpie_stack #(
    .STACK_DEPTH(STACK_DEPTH),
    .PC_WIDTH   (PC_WIDTH)
  ) u_stack (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (sctl_gated),
    .push_addr(ret_addr),
    .pop_addr (pop_addr)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_instr <= instr_word;
      hold_file  <= file_value;
      hold_page  <= page_bits;
    end
  end

  // Architectural state: advance only when the instruction retires
  always_ff @(posedge clk) begin
    if (rst) begin
      work_reg     <= 8'd0;
      status_flags <= FLAGS_RESET;
      prog_counter <= '0;
    end else if (advance) begin
      work_reg     <= res.w_value;
      status_flags <= res.flags;
      prog_counter <= res.next_pc[PC_WIDTH-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      file_write    <= res.file_write;
      file_addr     <= hold_instr[6:0];
      write_data    <= res.write_data;
      w_value       <= res.w_value;
      flags         <= res.flags;
      next_pc       <= res.next_pc;
      sleep_request <= res.sleep_request;
      option_write  <= res.option_write;
      irq_return    <= res.irq_return;
    end
  end

  `MPIE_ASSERT_SAME(a_no_push_pop, hold_valid, !(sctl.push && sctl.pop), "stack push and pop together")
  `MPIE_ASSERT_NEXT(a_retire_shows, advance, out_valid, "retired instruction gave no result")
  `MPIE_ASSERT_SAME(a_sleep_pd, out_valid && sleep_request, !flags[FL_PD], "SLEEP left PD set")
  `MPIE_ASSERT_SAME(a_nowrite_zero, out_valid && !file_write, write_data == 8'd0, "write data without write")
  `MPIE_ASSERT_NEXT(a_pc_follows, advance, prog_counter == next_pc[PC_WIDTH-1:0], "PC and result differ")

endmodule

`default_nettype wire

[dv/midrange_pic_instruction_execute_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midrange_pic_instruction_execute_unit_tb
// Feeds instruction words, file bytes and page bits into the execute unit and
// keeps its own copy of W, the status flags, the program counter and the
// return stack. Every result transfer is checked field by field against the
// oldest expected retirement. A directed run of corner cases comes first, then
// random programs under four mixes of sender idling and result-side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module midrange_pic_instruction_execute_unit_tb;
  import mpie_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PRINT_LIMIT  = 200;

  typedef struct packed {
    logic        file_write;
    logic [6:0]  file_addr;
    logic [7:0]  write_data;
    logic [7:0]  w_value;
    logic [4:0]  flags;
    logic [12:0] next_pc;
    logic        sleep_request;
    logic        option_write;
    logic        irq_return;
  } retire_t;

  // Architectural state of the core plus the queue of retirements still due.
  class core_tracker;
    logic [7:0]  w;
    logic [4:0]  st;
    logic [12:0] pc;
    logic [12:0] stack [DEPTH];
    bit          written [DEPTH];
    int unsigned sp;
    retire_t     retire_q [$];
    int          mismatches;
    int          seen;

    function new();
      w = '0;
      st = FLAGS_RESET;
      pc = '0;
      sp = 0;
      mismatches = 0;
      seen = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function logic [7:0] add8(logic [7:0] a, logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      st[FL_Z]  = (s[7:0] == 8'd0);
      st[FL_C]  = s[8];
      st[FL_DC] = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'd15;
      return s[7:0];
    endfunction

    function logic [7:0] sub8(logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      r = a - b;
      st[FL_Z]  = (r == 8'd0);
      st[FL_C]  = (a >= b);
      st[FL_DC] = (a[3:0] >= b[3:0]);
      return r;
    endfunction

    function void push(logic [12:0] a);
      stack[sp] = a;
      written[sp] = 1'b1;
      sp = (sp + 1) % DEPTH;
    endfunction

    function logic [12:0] pop();
      sp = (sp + DEPTH - 1) % DEPTH;
      return stack[sp];
    endfunction

    function bit can_pop();
      return written[(sp + DEPTH - 1) % DEPTH];
    endfunction

    // Execute one accepted instruction and queue the retirement it must produce.
    function void note(logic [13:0] iw, logic [7:0] fv, logic [1:0] pg);
      retire_t     e;
      logic [12:0] pc1;
      logic [12:0] npc;
      logic [7:0]  r;
      logic [7:0]  m;
      logic [7:0]  k;
      logic [3:0]  op;
      logic        d;
      logic        skip;
      logic        dest;
      logic        zop;
      e = '0;
      e.file_addr = iw[6:0];
      pc1 = pc + 13'd1;
      npc = pc1;
      skip = 1'b0;
      op = iw[11:8];
      d = iw[7];
      k = iw[7:0];
      case (iw[13:12])
        CLS_BYTE: begin
          if (iw[13:7] == 7'd0) begin
            case (iw[6:0])
              MISC_RETURN: npc = pop();
              MISC_RETFIE: begin
                npc = pop();
                e.irq_return = 1'b1;
              end
              MISC_OPTION: e.option_write = 1'b1;
              MISC_SLEEP: begin
                st[FL_PD] = 1'b0;
                st[FL_TO] = 1'b1;
                e.sleep_request = 1'b1;
              end
              MISC_CLRWDT: begin
                st[FL_PD] = 1'b1;
                st[FL_TO] = 1'b1;
              end
              default: ;
            endcase
          end else begin
            dest = 1'b1;
            zop = 1'b0;
            r = '0;
            case (op)
              OP_MOVWF: begin
                e.file_write = 1'b1;
                e.write_data = w;
                dest = 1'b0;
              end
              OP_CLR: begin
                st[FL_Z] = 1'b1;
                if (d) e.file_write = 1'b1;
                else w = '0;
                dest = 1'b0;
              end
              OP_SUBWF:  r = sub8(fv, w);
              OP_DECF:   begin r = fv - 8'd1; zop = 1'b1; end
              OP_IORWF:  begin r = fv | w; zop = 1'b1; end
              OP_ANDWF:  begin r = fv & w; zop = 1'b1; end
              OP_XORWF:  begin r = fv ^ w; zop = 1'b1; end
              OP_ADDWF:  r = add8(fv, w);
              OP_MOVF:   begin r = fv; zop = 1'b1; end
              OP_COMF:   begin r = ~fv; zop = 1'b1; end
              OP_INCF:   begin r = fv + 8'd1; zop = 1'b1; end
              OP_DECFSZ: begin r = fv - 8'd1; skip = (r == 8'd0); end
              OP_RRF: begin
                r = {st[FL_C], fv[7:1]};
                st[FL_C] = fv[0];
              end
              OP_RLF: begin
                r = {fv[6:0], st[FL_C]};
                st[FL_C] = fv[7];
              end
              OP_SWAPF:  r = {fv[3:0], fv[7:4]};
              OP_INCFSZ: begin r = fv + 8'd1; skip = (r == 8'd0); end
            endcase
            if (zop) st[FL_Z] = (r == 8'd0);
            if (dest) begin
              if (d) begin
                e.file_write = 1'b1;
                e.write_data = r;
              end else begin
                w = r;
              end
            end
          end
        end
        CLS_BIT: begin
          m = 8'd1 << iw[9:7];
          case (iw[11:10])
            BOP_BCF: begin
              e.file_write = 1'b1;
              e.write_data = fv & ~m;
            end
            BOP_BSF: begin
              e.file_write = 1'b1;
              e.write_data = fv | m;
            end
            BOP_BTFSC: skip = ((fv & m) == 8'd0);
            BOP_BTFSS: skip = ((fv & m) != 8'd0);
          endcase
        end
        CLS_JUMP: begin
          if (!iw[11]) push(pc1);
          npc = {pg, iw[10:0]};
        end
        CLS_LIT: begin
          case (op)
            LOP_MOVLW0, LOP_MOVLW1, LOP_MOVLW2, LOP_MOVLW3: w = k;
            LOP_RETLW0, LOP_RETLW1, LOP_RETLW2, LOP_RETLW3: begin
              w = k;
              npc = pop();
            end
            LOP_IORLW: begin w = w | k; st[FL_Z] = (w == 8'd0); end
            LOP_ANDLW: begin w = w & k; st[FL_Z] = (w == 8'd0); end
            LOP_XORLW: begin w = w ^ k; st[FL_Z] = (w == 8'd0); end
            LOP_UNUSED: ;
            LOP_SUBLW0, LOP_SUBLW1: w = sub8(k, w);
            LOP_ADDLW0, LOP_ADDLW1: w = add8(k, w);
          endcase
        end
      endcase
      if (skip) npc = pc1 + 13'd1;
      pc = npc;
      e.w_value = w;
      e.flags = st;
      e.next_pc = pc;
      retire_q.push_back(e);
    endfunction

    task report(string name, logic [12:0] got, logic [12:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("ERROR result %0d %s: got %0h, expected %0h", seen, name, got, want);
    endtask

    task cmp(string name, logic [12:0] got, logic [12:0] want);
      if (got !== want) report(name, got, want);
    endtask

    task check(retire_t got);
      retire_t e;
      if (retire_q.size() == 0) begin
        report("unexpected transfer, next_pc", got.next_pc, 'x);
      end else begin
        e = retire_q.pop_front();
        cmp("file_write", 13'(got.file_write), 13'(e.file_write));
        cmp("file_addr", 13'(got.file_addr), 13'(e.file_addr));
        cmp("write_data", 13'(got.write_data), 13'(e.write_data));
        cmp("w_value", 13'(got.w_value), 13'(e.w_value));
        cmp("flags", 13'(got.flags), 13'(e.flags));
        cmp("next_pc", got.next_pc, e.next_pc);
        cmp("sleep_request", 13'(got.sleep_request), 13'(e.sleep_request));
        cmp("option_write", 13'(got.option_write), 13'(e.option_write));
        cmp("irq_return", 13'(got.irq_return), 13'(e.irq_return));
      end
      seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [13:0] instr_word = '0;
  logic [7:0]  file_value = '0;
  logic [1:0]  page_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        file_write;
  logic [6:0]  file_addr;
  logic [7:0]  write_data;
  logic [7:0]  w_value;
  logic [4:0]  flags;
  logic [12:0] next_pc;
  logic        sleep_request;
  logic        option_write;
  logic        irq_return;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  core_tracker sb;

  always #5 clk = ~clk;

  midrange_pic_instruction_execute_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .instr_word   (instr_word),
    .file_value   (file_value),
    .page_bits    (page_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .file_write   (file_write),
    .file_addr    (file_addr),
    .write_data   (write_data),
    .w_value      (w_value),
    .flags        (flags),
    .next_pc      (next_pc),
    .sleep_request(sleep_request),
    .option_write (option_write),
    .irq_return   (irq_return)
  );

  function automatic logic [13:0] enc_byte(logic [3:0] op, logic d, logic [6:0] f);
    return {CLS_BYTE, op, d, f};
  endfunction

  function automatic logic [13:0] enc_bit(logic [1:0] bop, logic [2:0] b, logic [6:0] f);
    return {CLS_BIT, bop, b, f};
  endfunction

  // Bit 11 clear selects CALL, set selects GOTO.
  function automatic logic [13:0] enc_jump(logic call, logic [10:0] k);
    return {CLS_JUMP, ~call, k};
  endfunction

  function automatic logic [13:0] enc_lit(logic [3:0] op, logic [7:0] k);
    return {CLS_LIT, op, k};
  endfunction

  function automatic logic [13:0] enc_misc(logic [6:0] code);
    return {7'd0, code};
  endfunction

  function automatic bit is_return(logic [13:0] iw);
    return iw == enc_misc(MISC_RETURN) || iw == enc_misc(MISC_RETFIE) ||
           (iw[13:12] == CLS_LIT &&
            iw[11:8] inside {LOP_RETLW0, LOP_RETLW1, LOP_RETLW2, LOP_RETLW3});
  endfunction

  function automatic logic [13:0] pick_instr();
    logic [13:0] iw;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40)
      iw = enc_byte(4'($urandom_range(15)), 1'($urandom_range(1)), 7'($urandom_range(127)));
    else if (sel < 55)
      iw = enc_bit(2'($urandom_range(3)), 3'($urandom_range(7)), 7'($urandom_range(127)));
    else if (sel < 70)
      iw = enc_jump(1'($urandom_range(1)), 11'($urandom_range(2047)));
    else if (sel < 84)
      iw = enc_lit(4'($urandom_range(15)), 8'($urandom_range(255)));
    else if (sel < 93) begin
      case ($urandom_range(2))
        0: iw = enc_misc(MISC_RETURN);
        1: iw = enc_misc(MISC_RETFIE);
        default: iw = enc_lit(LOP_RETLW0 + 4'($urandom_range(3)), 8'($urandom_range(255)));
      endcase
    end else begin
      case ($urandom_range(4))
        0: iw = enc_misc(MISC_OPTION);
        1: iw = enc_misc(MISC_SLEEP);
        2: iw = enc_misc(MISC_CLRWDT);
        default: iw = enc_misc(7'($urandom_range(127)));
      endcase
    end
    // never return through a stack entry that no call has written
    if (is_return(iw) && !sb.can_pop())
      iw = enc_jump(1'b1, 11'($urandom_range(2047)));
    return iw;
  endfunction

  // Lean on the boundary bytes that drive skips, carries and zero results.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'h80;
      4: return sb.w;
      5: return ~sb.w;
      6: return 8'd0 - sb.w;
      7: return {sb.w[7:4], 4'h0};
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send(logic [13:0] iw, logic [7:0] fv, logic [1:0] pg);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    instr_word <= iw;
    file_value <= fv;
    page_bits  <= pg;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note(iw, fv, pg);
  endtask

  // Check each result transfer, then decide the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall)
      sb.check({file_write, file_addr, write_data, w_value, flags, next_pc,
                sleep_request, option_write, irq_return});
    out_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send(enc_lit(LOP_MOVLW0, 8'hFF), 8'h00, 2'd0);
    send(enc_lit(LOP_ADDLW1, 8'h01), 8'hFF, 2'd3);
    // write-back to STATUS must leave the internal flags alone
    send(enc_byte(OP_MOVWF, 1'b1, 7'h03), 8'hFF, 2'd0);
    send(enc_byte(OP_CLR, 1'b0, 7'h7F), 8'hFF, 2'd0);
    send(enc_byte(OP_CLR, 1'b1, 7'h00), 8'h00, 2'd0);
    send(enc_lit(LOP_MOVLW3, 8'h01), 8'h00, 2'd0);
    send(enc_lit(LOP_SUBLW0, 8'h00), 8'h00, 2'd0);
    send(enc_byte(OP_SUBWF, 1'b0, 7'h10), 8'h00, 2'd0);
    send(enc_byte(OP_DECFSZ, 1'b0, 7'h20), 8'h01, 2'd0);
    send(enc_byte(OP_INCFSZ, 1'b1, 7'h7F), 8'hFF, 2'd0);
    send(enc_byte(OP_RRF, 1'b1, 7'h21), 8'h01, 2'd0);
    send(enc_byte(OP_RLF, 1'b0, 7'h22), 8'h80, 2'd0);
    send(enc_byte(OP_SWAPF, 1'b1, 7'h23), 8'hA5, 2'd0);
    send(enc_bit(BOP_BTFSC, 3'd7, 7'h24), 8'h7F, 2'd0);
    send(enc_bit(BOP_BTFSS, 3'd0, 7'h25), 8'h01, 2'd0);
    send(enc_bit(BOP_BSF, 3'd7, 7'h26), 8'h00, 2'd0);
    send(enc_bit(BOP_BCF, 3'd0, 7'h27), 8'hFF, 2'd0);
    // jump to the top of program memory, then let a taken skip wrap the counter
    send(enc_jump(1'b0, 11'h7FF), 8'h00, 2'd3);
    send(enc_byte(OP_DECFSZ, 1'b1, 7'h28), 8'h01, 2'd0);
    send(enc_jump(1'b1, 11'h7FF), 8'h00, 2'd3);
    send(enc_misc(MISC_RETURN), 8'h00, 2'd0);
    send(enc_jump(1'b1, 11'h000), 8'h00, 2'd0);
    send(enc_lit(LOP_RETLW3, 8'h5A), 8'h00, 2'd0);
    send(enc_jump(1'b1, 11'h155), 8'h00, 2'd2);
    send(enc_misc(MISC_RETFIE), 8'h00, 2'd0);
    send(enc_misc(MISC_OPTION), 8'h00, 2'd0);
    send(enc_misc(MISC_SLEEP), 8'h00, 2'd0);
    send(enc_misc(MISC_CLRWDT), 8'h00, 2'd0);
    send(enc_misc(7'h7F), 8'hFF, 2'd0);
    send(enc_lit(LOP_UNUSED, 8'hFF), 8'hFF, 2'd0);
    send(enc_lit(LOP_ADDLW1, 8'hFF), 8'hFF, 2'd3);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      repeat (RANDOM_ITEMS / 4) send(pick_instr(), pick_byte(), 2'($urandom_range(3)));
    end

    in_valid <= 1'b0;
    while (sb.retire_q.size() != 0) @(posedge clk);
    // catch any stray transfer after the last expected one
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
